### design/lse_pkg.sv
// lse_pkg: shared constants for the log-sum-exp approximation datapath
// holds the Q.28 cubic coefficient table and the accumulator width
// no dependencies
`timescale 1ns / 1ps

package lse_pkg;

  // coefficient and accumulator format
  localparam int COEF_FRAC = 28;
  localparam int ACC_W     = 32;
  localparam int NUM_SEG   = 4;
  localparam int NUM_TERM  = 4;

  typedef logic [1:0] seg_t;

  // decimal coefficient given in units of 1e-15, scaled to Q.28 with rounding to nearest
  function automatic logic signed [ACC_W-1:0] qc(input logic [63:0] n);
    logic [63:0] t;
    t = (n * 64'd8192 + 64'd15258789062) / 64'd30517578125;
    return ACC_W'(t);
  endfunction

  // rows are segments, columns are Horner terms from the cubic term down
  localparam logic signed [ACC_W-1:0] COEF [NUM_SEG][NUM_TERM] = '{
    '{-qc(64'd9350833524763),  qc(64'd130659527668286),
       qc(64'd498799810682272), qc(64'd693203116424741)},
    '{-qc(64'd14532321752540), qc(64'd139942324101744),
       qc(64'd495635523139337), qc(64'd692140569840976)},
    '{-qc(64'd4605031767994),  qc(64'd63427417320019),
       qc(64'd695956496475118), qc(64'd514272634594009)},
    '{-qc(64'd458661602210),   qc(64'd9695946122598),
       qc(64'd930734667215156), qc(64'd168037164329057)}
  };

endpackage

### design/log_sum_exp_approx.sv
// log_sum_exp_approx: ten-stage pipeline for log(exp(a) + exp(b))
// uses lse_pkg for the coefficient table and accumulator width
// throughput: one item per cycle
// busy_o is always low, the pipeline never stalls and the receiver cannot stall
// reset: asynchronous active low, clears the valid bits and sets
//   log_zero_floor to the most negative value; no clearing pass
`timescale 1ns / 1ps

module log_sum_exp_approx import lse_pkg::*; #(
  parameter int VALUE_BITS = 48,
  parameter int FRAC_BITS  = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item input
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [VALUE_BITS-1:0] first_log_i,
  input  logic signed [VALUE_BITS-1:0] second_log_i,
  // log-zero floor register
  input  logic                         log_zero_floor_we_i,
  input  logic signed [VALUE_BITS-1:0] log_zero_floor_i,
  // result output, one cycle strobe
  output logic                         done_o,
  output logic signed [VALUE_BITS-1:0] sum_log_o,
  output logic                         passed_through_o,
  output logic                         saturated_o
);

  localparam int W      = VALUE_BITS;
  localparam int F      = FRAC_BITS;
  // below 7.5 the difference needs three integer bits
  localparam int DW     = F + 3;
  // signed accumulator times zero-extended difference
  localparam int PW     = ACC_W + DW + 1;
  localparam int CORR_W = ACC_W + 2;
  localparam int SUM_W  = ((W > CORR_W) ? W : CORR_W) + 2;
  localparam int DCMP_W = (W > F + 4) ? W : F + 4;
  localparam int NS     = 10;

  localparam logic [DCMP_W-1:0] PASS_LIM = DCMP_W'(15) << (F - 1);
  localparam logic [DW-1:0]     SEG1_LIM = DW'(1) << F;
  localparam logic [DW-1:0]     SEG2_LIM = DW'(5) << (F - 1);
  localparam logic [DW-1:0]     SEG3_LIM = DW'(9) << (F - 1);
  localparam logic signed [SUM_W-1:0] FMT_MAX =
    $signed({{(SUM_W - W + 1){1'b0}}, {(W - 1){1'b1}}});
  localparam logic signed [W-1:0] FMT_MAX_W = $signed({1'b0, {(W - 1){1'b1}}});

  // product back to Q.28: round to nearest, ties toward plus infinity
  function automatic logic signed [ACC_W-1:0] rnd_prod(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + (PW'(1) << (F - 1));
    return ACC_W'(t >>> F);
  endfunction

  // log-zero floor register
  logic signed [W-1:0] floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= $signed({1'b1, {(W - 1){1'b0}}});
    end else if (log_zero_floor_we_i) begin
      floor_q <= log_zero_floor_i;
    end
  end

  // valid bits, one per stage
  logic [NS:1] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NS-1:1], start_i};
    end
  end

  // ---------------------------------------------------------------
  // stage 1: order operands, form difference, floor check
  // both subtractions and both floor compares run in parallel
  // ---------------------------------------------------------------
  logic                lt;
  logic signed [W-1:0] larger_d, smaller_d;
  logic [W-1:0]        diff_d;
  logic                low_d;
  logic signed [W-1:0] larger_q1, smaller_q1;
  logic [W-1:0]        diff_q1;
  logic                low_q1;

  always_comb begin
    lt        = first_log_i < second_log_i;
    // equal operands: the second one counts as smaller
    larger_d  = lt ? second_log_i : first_log_i;
    smaller_d = lt ? first_log_i : second_log_i;
    // true difference always fits W bits unsigned, wrap is exact
    diff_d    = lt ? W'(second_log_i - first_log_i) : W'(first_log_i - second_log_i);
    low_d     = lt ? (first_log_i <= floor_q) : (second_log_i <= floor_q);
  end

  always_ff @(posedge clk_i) begin
    larger_q1  <= larger_d;
    smaller_q1 <= smaller_d;
    diff_q1    <= diff_d;
    low_q1     <= low_d;
  end

  // ---------------------------------------------------------------
  // stage 2: pass-through decision and segment pick
  // fields then ride along a shift line to the last stage
  // ---------------------------------------------------------------
  logic [DW-1:0]       dsh_d;
  seg_t                seg_d;
  logic                pass_d;

  logic signed [W-1:0] larger_q  [2:NS-1];
  logic signed [W-1:0] smaller_q [2:NS-1];
  logic                pass_q    [2:NS-1];
  logic [DW-1:0]       dsh_q     [2:NS-1];
  seg_t                seg_q     [2:NS-1];

  always_comb begin
    pass_d = low_q1 || (DCMP_W'(diff_q1) >= PASS_LIM);
    // truncation only matters when the item passes through
    dsh_d  = DW'(diff_q1);
    // segment edges belong to the lower segment
    if (dsh_d <= SEG1_LIM) begin
      seg_d = seg_t'(0);
    end else if (dsh_d <= SEG2_LIM) begin
      seg_d = seg_t'(1);
    end else if (dsh_d <= SEG3_LIM) begin
      seg_d = seg_t'(2);
    end else begin
      seg_d = seg_t'(3);
    end
  end

  always_ff @(posedge clk_i) begin
    larger_q[2]  <= larger_q1;
    smaller_q[2] <= smaller_q1;
    pass_q[2]    <= pass_d;
    dsh_q[2]     <= dsh_d;
    seg_q[2]     <= seg_d;
    for (int k = 3; k < NS; k++) begin
      larger_q[k]  <= larger_q[k-1];
      smaller_q[k] <= smaller_q[k-1];
      pass_q[k]    <= pass_q[k-1];
      dsh_q[k]     <= dsh_q[k-1];
      seg_q[k]     <= seg_q[k-1];
    end
  end

  // ---------------------------------------------------------------
  // stages 3 to 8: Horner evaluation, multiply and round-add alternate
  // each multiply is registered before its round and add
  // ---------------------------------------------------------------
  logic signed [PW-1:0]    prod_q3, prod_q5, prod_q7;
  logic signed [ACC_W-1:0] acc_q4, acc_q6, acc_q8;

  always_ff @(posedge clk_i) begin
    prod_q3 <= COEF[seg_q[2]][0] * $signed({1'b0, dsh_q[2]});
    acc_q4  <= rnd_prod(prod_q3) + COEF[seg_q[3]][1];
    prod_q5 <= acc_q4 * $signed({1'b0, dsh_q[4]});
    acc_q6  <= rnd_prod(prod_q5) + COEF[seg_q[5]][2];
    prod_q7 <= acc_q6 * $signed({1'b0, dsh_q[6]});
    acc_q8  <= rnd_prod(prod_q7) + COEF[seg_q[7]][3];
  end

  // ---------------------------------------------------------------
  // stage 9: correction from Q.28 to the operand format
  // ---------------------------------------------------------------
  logic signed [CORR_W-1:0] corr_d, corr_q9;

  generate
    if (F < COEF_FRAC) begin : g_corr_down
      logic signed [CORR_W-1:0] corr_t;
      always_comb begin
        corr_t = CORR_W'(acc_q8) + (CORR_W'(1) << (COEF_FRAC - F - 1));
        corr_d = corr_t >>> (COEF_FRAC - F);
      end
    end else if (F == COEF_FRAC) begin : g_corr_same
      assign corr_d = CORR_W'(acc_q8);
    end else begin : g_corr_up
      assign corr_d = CORR_W'(acc_q8) <<< (F - COEF_FRAC);
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    corr_q9 <= corr_d;
  end

  // ---------------------------------------------------------------
  // stage 10: add to the smaller operand, saturate, select pass-through
  // ---------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_d;
  logic                    sat_d;
  logic signed [W-1:0]     res_d;
  logic signed [W-1:0]     sum_log_q;
  logic                    passed_q, sat_q;

  always_comb begin
    sum_d = SUM_W'(smaller_q[NS-1]) + SUM_W'(corr_q9);
    // correction is positive, only the top can be exceeded
    sat_d = !pass_q[NS-1] && (sum_d > FMT_MAX);
    if (pass_q[NS-1]) begin
      res_d = larger_q[NS-1];
    end else if (sat_d) begin
      res_d = FMT_MAX_W;
    end else begin
      res_d = W'(sum_d);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_log_q <= res_d;
    passed_q  <= pass_q[NS-1];
    sat_q     <= sat_d;
  end

  assign busy_o           = 1'b0;
  assign done_o           = valid_q[NS];
  assign sum_log_o        = sum_log_q;
  assign passed_through_o = passed_q;
  assign saturated_o      = sat_q;

endmodule

### dv/log_sum_exp_approx_checker.sv
// log_sum_exp_approx_checker: predicts the log-sum result of every accepted item and
// compares it with the result port of log_sum_exp_approx; keeps its own copy of the floor
// depends on nothing but the ports of the block
`timescale 1ns / 1ps

module log_sum_exp_approx_checker #(
  parameter int VALUE_BITS = 48,
  parameter int FRAC_BITS  = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item channel
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic signed [VALUE_BITS-1:0] first_log_i,
  input  logic signed [VALUE_BITS-1:0] second_log_i,
  // floor register write
  input  logic                         floor_we_i,
  input  logic signed [VALUE_BITS-1:0] floor_i,
  // result channel
  input  logic                         done_i,
  input  logic signed [VALUE_BITS-1:0] sum_log_i,
  input  logic                         passed_through_i,
  input  logic                         saturated_i,
  output int                           mismatches_o,
  output int                           pending_o
);

  localparam int     COEF_Q  = 28;
  localparam int     NUM_MSG = 10;
  localparam longint ONE     = longint'(1) <<< FRAC_BITS;
  localparam longint VAL_MAX = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
  localparam longint VAL_MIN = -VAL_MAX - 1;

  typedef struct {
    logic signed [VALUE_BITS-1:0] sum_log;
    logic                         passed;
    logic                         sat;
  } lse_result_t;

  longint                       cubic_coef [4][4];
  logic signed [VALUE_BITS-1:0] floor_copy;
  lse_result_t                  pending_sums [$];

  // coefficient given in units of 1e-15, scaled to Q.28 and rounded to nearest
  function automatic longint q28(input longint unsigned n);
    logic [127:0] scaled;
    scaled = (128'(n) << COEF_Q) + 128'd500000000000000;
    scaled = scaled / 128'd1000000000000000;
    return longint'(scaled[63:0]);
  endfunction

  // floor((v + half) / 2^s)
  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  initial begin
    // rows split at d of 1.0, 2.5 and 4.5; columns from the cubic term down
    cubic_coef[0] = '{-q28(64'd9350833524763), q28(64'd130659527668286),
                      q28(64'd498799810682272), q28(64'd693203116424741)};
    cubic_coef[1] = '{-q28(64'd14532321752540), q28(64'd139942324101744),
                      q28(64'd495635523139337), q28(64'd692140569840976)};
    cubic_coef[2] = '{-q28(64'd4605031767994), q28(64'd63427417320019),
                      q28(64'd695956496475118), q28(64'd514272634594009)};
    cubic_coef[3] = '{-q28(64'd458661602210), q28(64'd9695946122598),
                      q28(64'd930734667215156), q28(64'd168037164329057)};
  end

  function automatic lse_result_t jacobian_log_sum(
    input logic signed [VALUE_BITS-1:0] a,
    input logic signed [VALUE_BITS-1:0] b,
    input logic signed [VALUE_BITS-1:0] floor_v
  );
    longint      hi, lo, diff, acc, corr;
    int          seg;
    lse_result_t r;
    // ties go to the second operand as the smaller one
    if (a < b) begin
      hi = b;
      lo = a;
    end else begin
      hi = a;
      lo = b;
    end
    diff     = hi - lo;
    r.passed = 1'b0;
    r.sat    = 1'b0;
    if (lo <= floor_v || diff >= 15 * ONE / 2) begin
      r.sum_log = VALUE_BITS'(hi);
      r.passed  = 1'b1;
      return r;
    end
    if (diff <= ONE) begin
      seg = 0;
    end else if (diff <= 5 * ONE / 2) begin
      seg = 1;
    end else if (diff <= 9 * ONE / 2) begin
      seg = 2;
    end else begin
      seg = 3;
    end
    acc = cubic_coef[seg][0];
    for (int k = 1; k < 4; k++) begin
      acc = rnd_shift(acc * diff, FRAC_BITS) + cubic_coef[seg][k];
    end
    corr = rnd_shift(acc, COEF_Q - FRAC_BITS);
    if (lo > VAL_MAX - corr) begin
      r.sum_log = VALUE_BITS'(VAL_MAX);
      r.sat     = 1'b1;
    end else begin
      r.sum_log = VALUE_BITS'(lo + corr);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input lse_result_t want,
                                 input lse_result_t got);
    mismatches_o++;
    if (mismatches_o <= NUM_MSG) begin
      $display("%0t mismatch, %s: expected sum_log %0d passed %0b saturated %0b",
               $time, what, want.sum_log, want.passed, want.sat);
      $display("%0t             got sum_log %0d passed %0b saturated %0b",
               $time, got.sum_log, got.passed, got.sat);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lse_result_t want, got;
    if (!rst_ni) begin
      floor_copy = VALUE_BITS'(VAL_MIN);
      pending_sums.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // results first: an item accepted at this edge is still in the pipeline
      if (done_i) begin
        got.sum_log = sum_log_i;
        got.passed  = passed_through_i;
        got.sat     = saturated_i;
        if (pending_sums.size() == 0) begin
          want = '{sum_log: '0, passed: 1'b0, sat: 1'b0};
          report_mismatch("result with no item outstanding", want, got);
        end else begin
          want = pending_sums.pop_front();
          if (want.sum_log !== got.sum_log || want.passed !== got.passed ||
              want.sat !== got.sat) begin
            report_mismatch("wrong result", want, got);
          end
        end
      end
      // append the prediction at the tail of the queue
      if (start_i && !busy_i) begin
        pending_sums = {pending_sums,
                        jacobian_log_sum(first_log_i, second_log_i, floor_copy)};
      end
      if (floor_we_i) begin
        floor_copy = floor_i;
      end
      pending_o = pending_sums.size();
    end
  end

endmodule

### dv/log_sum_exp_approx_tb.sv
// log_sum_exp_approx_tb: stimulus and verdict for the log-sum-exp approximation block
// instantiates log_sum_exp_approx and log_sum_exp_approx_checker side by side
`timescale 1ns / 1ps

module log_sum_exp_approx_tb;

  localparam int     VW              = 48;
  localparam int     FW              = 24;
  localparam longint ONE             = longint'(1) <<< FW;
  localparam longint VAL_MAX         = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VAL_MIN         = -VAL_MAX - 1;
  localparam int     ITEMS_PER_PHASE = 117;
  // pipeline is ten deep, let it settle after the last result before the verdict
  localparam int     SETTLE_CYCLES   = 20;
  localparam int     WATCHDOG_LIMIT  = 500;

  typedef logic signed [VW-1:0] log_val_t;

  logic     clk_i;
  logic     rst_ni              = 1'b0;
  logic     start_i             = 1'b0;
  logic     busy_o;
  log_val_t first_log_i         = '0;
  log_val_t second_log_i        = '0;
  logic     log_zero_floor_we_i = 1'b0;
  log_val_t log_zero_floor_i    = '0;
  logic     done_o;
  log_val_t sum_log_o;
  logic     passed_through_o;
  logic     saturated_o;

  int       mismatches;
  int       pending;
  int       idle_cycles = 0;
  // items left in the current burst; zero means a gap comes first
  int       burst_left  = 0;
  // floor currently programmed, used to aim items at the log-zero boundary
  longint   cur_floor   = VAL_MIN;

  log_sum_exp_approx #(
    .VALUE_BITS (VW),
    .FRAC_BITS  (FW)
  ) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .first_log_i         (first_log_i),
    .second_log_i        (second_log_i),
    .log_zero_floor_we_i (log_zero_floor_we_i),
    .log_zero_floor_i    (log_zero_floor_i),
    .done_o              (done_o),
    .sum_log_o           (sum_log_o),
    .passed_through_o    (passed_through_o),
    .saturated_o         (saturated_o)
  );

  log_sum_exp_approx_checker #(
    .VALUE_BITS (VW),
    .FRAC_BITS  (FW)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .first_log_i      (first_log_i),
    .second_log_i     (second_log_i),
    .floor_we_i       (log_zero_floor_we_i),
    .floor_i          (log_zero_floor_i),
    .done_i           (done_o),
    .sum_log_i        (sum_log_o),
    .passed_through_i (passed_through_o),
    .saturated_i      (saturated_o),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: any edge with an accepted item or a result counts as progress
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // clamp a wide value into the operand format
  function automatic log_val_t to_val(input longint v);
    if (v > VAL_MAX) begin
      return log_val_t'(VAL_MAX);
    end
    if (v < VAL_MIN) begin
      return log_val_t'(VAL_MIN);
    end
    return log_val_t'(v);
  endfunction

  function automatic log_val_t rand_val();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return log_val_t'(r[VW-1:0]);
  endfunction

  // lower start and idle
  task automatic idle_for(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // one item, with the sender's burst and gap pattern folded in
  task automatic send_pair(input log_val_t a, input log_val_t b);
    if (burst_left == 0) begin
      // mostly short gaps, now and then a long one
      if ($urandom_range(0, 5) == 0) begin
        idle_for($urandom_range(8, 30));
      end else begin
        idle_for($urandom_range(1, 4));
      end
      // occasional long burst gives back-to-back stretches with no gap at all
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(40, 120);
      end else begin
        burst_left = $urandom_range(1, 24);
      end
    end
    burst_left--;
    start_i      <= 1'b1;
    first_log_i  <= a;
    second_log_i <= b;
    do @(posedge clk_i); while (busy_o);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_pipeline();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // floor is only written with the pipeline empty
  task automatic write_floor(input longint v);
    drain_pipeline();
    log_zero_floor_we_i <= 1'b1;
    log_zero_floor_i    <= to_val(v);
    @(posedge clk_i);
    log_zero_floor_we_i <= 1'b0;
    cur_floor = v;
  endtask

  // random operand pair, weighted toward the correction range
  task automatic pick_pair(output log_val_t a, output log_val_t b);
    longint      hi, lo, diff, jitter;
    int unsigned mode;
    mode   = $urandom_range(0, 99);
    diff   = $urandom_range(0, (15 << 23) + (1 << 22));
    jitter = $urandom_range(0, 4);
    jitter -= 2;
    // equal operands now and then
    if ($urandom_range(0, 19) == 0) begin
      diff = 0;
    end
    if (mode < 55) begin
      // well-formed pair, operand magnitude from tiny to full scale
      hi = longint'(rand_val()) >>> $urandom_range(0, 24);
      lo = hi - diff;
    end else if (mode < 65) begin
      // difference within a few lsb of a segment boundary or the cutoff
      hi = longint'(rand_val()) >>> 8;
      case ($urandom_range(0, 3))
        0:       diff = ONE;
        1:       diff = 5 * ONE / 2;
        2:       diff = 9 * ONE / 2;
        default: diff = 15 * ONE / 2;
      endcase
      lo = hi - (diff + jitter);
    end else if (mode < 75) begin
      // just under the format maximum, where the correction can overflow
      hi = VAL_MAX - longint'($urandom_range(0, 1 << 24));
      lo = hi - (diff >>> 3);
    end else if (mode < 85) begin
      // smaller operand around the log-zero floor
      lo = cur_floor + jitter;
      hi = lo + diff;
    end else begin
      // noise: any two values, mostly huge differences
      hi = rand_val();
      lo = rand_val();
    end
    if ($urandom_range(0, 1) == 1) begin
      a = to_val(hi);
      b = to_val(lo);
    end else begin
      a = to_val(lo);
      b = to_val(hi);
    end
  endtask

  initial begin : stimulus
    log_val_t a, b;
    longint   floors [6];

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, floor at its reset value
    send_pair(to_val(0), to_val(0));                        // equal operands
    send_pair(to_val(1), to_val(0));                        // one lsb apart
    send_pair(to_val(ONE), to_val(0));                      // d exactly 1.0
    send_pair(to_val(0), to_val(ONE + 1));                  // just past 1.0, second larger
    send_pair(to_val(5 * ONE / 2), to_val(0));              // d exactly 2.5
    send_pair(to_val(0), to_val(5 * ONE / 2 + 1));
    send_pair(to_val(9 * ONE / 2), to_val(0));              // d exactly 4.5
    send_pair(to_val(9 * ONE / 2 + 1), to_val(0));
    send_pair(to_val(15 * ONE / 2 - 1), to_val(0));         // last d below the cutoff
    send_pair(to_val(15 * ONE / 2), to_val(0));             // d at the cutoff passes
    send_pair(to_val(VAL_MAX), to_val(VAL_MAX));            // overflow saturates
    send_pair(to_val(VAL_MAX), to_val(VAL_MAX - ONE));
    send_pair(to_val(VAL_MIN), to_val(VAL_MIN));            // at the floor
    send_pair(to_val(VAL_MIN + 1), to_val(VAL_MIN + 1));    // just above the floor
    send_pair(to_val(VAL_MAX), to_val(VAL_MIN));            // huge difference
    send_pair(to_val(VAL_MIN), to_val(VAL_MAX));
    send_pair(to_val(-1), to_val(0));
    send_pair(to_val(-3 * ONE), to_val(-3 * ONE - 7));
    send_pair(log_val_t'(48'h5555_5555_5555), log_val_t'(48'hAAAA_AAAA_AAAA));

    // floor at zero: operands at or below it pass through
    write_floor(0);
    send_pair(to_val(0), to_val(ONE));
    send_pair(to_val(1), to_val(ONE));
    send_pair(to_val(-ONE), to_val(-ONE));

    // floor at the top: everything passes, nothing saturates
    write_floor(VAL_MAX);
    send_pair(to_val(VAL_MAX), to_val(VAL_MAX));
    send_pair(to_val(VAL_MAX), to_val(VAL_MAX - ONE));

    // random phases, each under its own floor
    floors = '{VAL_MIN, 0, longint'(rand_val()), -20 * ONE, longint'(rand_val()), VAL_MAX};
    foreach (floors[p]) begin
      write_floor(floors[p]);
      repeat (ITEMS_PER_PHASE) begin
        pick_pair(a, b);
        send_pair(a, b);
      end
    end

    drain_pipeline();
    // stray results after the last one would show up as mismatches here
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
